FILE: sv/pta_pkg.sv
`default_nettype none

package pta_pkg;

   // Field and register widths.
   localparam int TICK_W    = 16;
   localparam int ACC_W     = 17;
   localparam int BIT_IDX_W = 5;
   localparam int COUNT_W   = 32;
   localparam int FACTOR_W  = 32;
   localparam int PROD_W    = 64;
   localparam int TOTAL_W   = 48;
   localparam int WIDTH_W   = 47;
   localparam int DEV_W     = 49;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 48;

   // Register values after reset.
   localparam logic [TICK_W-1:0]   PERIOD_RESET = 16'd1000;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 32'd65536;

   // Saturation limit of the total, 2^47 - 1.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONTROL_PERIOD = 2'd0,
      CSR_PULSE_FACTOR   = 2'd1,
      CSR_PRESET_VALUE   = 2'd2,
      CSR_PREALARM_WIDTH = 2'd3
   } csr_index_type;

   // Block status codes.
   typedef enum logic [1:0] {
      STATUS_NORMAL   = 2'd0,
      STATUS_PREALARM = 2'd1,
      STATUS_COUNTUP  = 2'd2,
      STATUS_PAUSED   = 2'd3
   } block_status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MOD,
      ST_MUL,
      ST_ADD,
      ST_CMP,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_in;
      logic acc_keep;
      logic acc_sub;
      logic mod_start;
      logic mod_step;
      logic mul;
      logic add;
      logic cmp;
      logic publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exec_needed;
      logic one_sub;
      logic mod_last;
      logic run_add;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: sv/pta_req_if.sv
`default_nettype none

interface pta_req_if
   import pta_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [TICK_W-1:0]  elapsed_ticks;
   logic [COUNT_W-1:0] pulse_count;
   logic               reset_request;
   logic               hold_switch;

   modport source (output valid, elapsed_ticks, pulse_count, reset_request, hold_switch,
                   input ready);
   modport sink (input valid, elapsed_ticks, pulse_count, reset_request, hold_switch,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/pta_rsp_if.sv
`default_nettype none

interface pta_rsp_if
   import pta_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      executed;
   logic signed [TOTAL_W-1:0] total_value;
   logic signed [DEV_W-1:0]   deviation;
   logic [1:0]                block_status;

   modport source (output valid, executed, total_value, deviation, block_status,
                   input ready);
   modport sink (input valid, executed, total_value, deviation, block_status,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/pta_ctrl.sv
`default_nettype none

module pta_ctrl
   import pta_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // The period has not elapsed, elapsed once, or elapsed many times.
            if (!stat.exec_needed) begin
               cmd.acc_keep = 1'b1;
               state_in     = ST_DONE;
            end else if (stat.one_sub) begin
               cmd.acc_sub = 1'b1;
               state_in    = ST_MUL;
            end else begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = stat.run_add ? ST_ADD : ST_DONE;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/pta_datapath.sv
`default_nettype none

module pta_datapath
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic [TICK_W-1:0]     in_elapsed_ticks,
   input  wire logic [COUNT_W-1:0]    in_pulse_count,
   input  wire logic                  in_reset_request,
   input  wire logic                  in_hold_switch,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic                       out_executed,
   output logic [TOTAL_W-1:0]         out_total_value,
   output logic [DEV_W-1:0]           out_deviation,
   output logic [1:0]                 out_block_status
);

   // Configuration registers.
   logic [TICK_W-1:0]   period_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic [TOTAL_W-1:0]  preset_ff;
   logic [WIDTH_W-1:0]  width_ff;

   // Item and totalizer state.
   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_W-1:0]     sum_ff;
   logic [BIT_IDX_W-1:0] bit_idx_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rst_ff;
   logic                 hold_ff;
   logic [COUNT_W-1:0]   last_count_ff;
   logic                 last_valid_ff;
   logic                 exec_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [DEV_W-1:0]     thr_ff;
   logic [TOTAL_W-1:0]   total_ff;
   logic [DEV_W-1:0]     dev_ff;
   block_status_type     status_ff;

   // Output register.
   logic               out_valid_ff;
   logic               out_exec_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic [DEV_W-1:0]   out_dev_ff;
   logic [1:0]         out_status_ff;

   logic [TICK_W-1:0]  period_eff;
   logic [ACC_W-1:0]   period_ext;
   logic [ACC_W-1:0]   shifted;
   logic [ACC_W-1:0]   mod_next;
   logic [COUNT_W-1:0] diff;
   logic [PROD_W-1:0]  prod_in;
   logic [DEV_W-1:0]   sum_wide;
   logic [TOTAL_W-1:0] total_sat;
   logic [DEV_W-1:0]   total_wide;
   logic [DEV_W-1:0]   preset_wide;
   logic [DEV_W-1:0]   dev_in;

   // A period of zero behaves as a period of one.
   assign period_eff = (period_ff == '0) ? TICK_W'(1) : period_ff;
   assign period_ext = {1'b0, period_eff};

   // One restoring step of the remainder: shift in the next dividend bit.
   assign shifted  = {acc_ff[ACC_W-2:0], sum_ff[bit_idx_ff]};
   assign mod_next = (shifted >= period_ext) ? (shifted - period_ext) : shifted;

   // Counter difference wraps at the counter width.
   assign diff    = count_ff - last_count_ff;
   assign prod_in = PROD_W'(factor_ff) * PROD_W'(diff);

   // Saturating add: the product is never negative, so only the top limit applies.
   assign sum_wide = {total_ff[TOTAL_W-1], total_ff} + {2'b00, prod_ff[WIDTH_W-1:0]};
   always_comb begin
      if (prod_ff[PROD_W-1:WIDTH_W] != '0) begin
         total_sat = TOTAL_MAX;
      end else if (!sum_wide[DEV_W-1] && sum_wide[TOTAL_W-1]) begin
         total_sat = TOTAL_MAX;
      end else begin
         total_sat = sum_wide[TOTAL_W-1:0];
      end
   end

   assign total_wide  = {total_ff[TOTAL_W-1], total_ff};
   assign preset_wide = {preset_ff[TOTAL_W-1], preset_ff};
   assign dev_in      = preset_wide - total_wide;

   // Status to the controller.
   assign stat.exec_needed = (sum_ff >= period_ext);
   assign stat.one_sub     = (sum_ff < {period_eff, 1'b0});
   assign stat.mod_last    = (bit_idx_ff == '0);
   assign stat.run_add     = last_valid_ff && !hold_ff;
   assign stat.out_free    = !out_valid_ff || out_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         factor_ff <= FACTOR_RESET;
         preset_ff <= '0;
         width_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONTROL_PERIOD: period_ff <= csr_write_data[TICK_W-1:0];
            CSR_PULSE_FACTOR:   factor_ff <= csr_write_data[FACTOR_W-1:0];
            CSR_PRESET_VALUE:   preset_ff <= csr_write_data[TOTAL_W-1:0];
            CSR_PREALARM_WIDTH: width_ff  <= csr_write_data[WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Item capture; these registers hold payload only.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sum_ff   <= acc_ff + ACC_W'(in_elapsed_ticks);
         count_ff <= in_pulse_count;
         rst_ff   <= in_reset_request;
         hold_ff  <= in_hold_switch;
      end
      if (cmd.mod_start) begin
         bit_idx_ff <= BIT_IDX_W'(ACC_W - 1);
      end else if (cmd.mod_step) begin
         bit_idx_ff <= bit_idx_ff - BIT_IDX_W'(1);
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         thr_ff  <= preset_wide - {2'b00, width_ff};
      end
   end

   // Tick accumulator and execution flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         exec_ff <= 1'b0;
      end else if (cmd.acc_keep) begin
         acc_ff  <= sum_ff;
         exec_ff <= 1'b0;
      end else if (cmd.acc_sub) begin
         acc_ff  <= sum_ff - period_ext;
         exec_ff <= 1'b1;
      end else if (cmd.mod_start) begin
         acc_ff  <= '0;
         exec_ff <= 1'b1;
      end else if (cmd.mod_step) begin
         acc_ff <= mod_next;
      end
   end

   // Totalizer state: latch counter, clear on request, add, compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         last_valid_ff <= 1'b0;
         total_ff      <= '0;
         dev_ff        <= '0;
         status_ff     <= STATUS_NORMAL;
      end else if (cmd.mul) begin
         last_count_ff <= count_ff;
         last_valid_ff <= 1'b1;
         if (rst_ff) begin
            total_ff <= '0;
         end
         if (hold_ff) begin
            status_ff <= STATUS_PAUSED;
         end
      end else if (cmd.add) begin
         total_ff <= total_sat;
      end else if (cmd.cmp) begin
         dev_ff <= dev_in;
         if ($signed(total_wide) < $signed(thr_ff)) begin
            status_ff <= STATUS_NORMAL;
         end else if ($signed(total_wide) >= $signed(preset_wide)) begin
            status_ff <= STATUS_COUNTUP;
         end else begin
            status_ff <= STATUS_PREALARM;
         end
      end
   end

   // Output register; frees the controller while a result waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_exec_ff   <= exec_ff;
         out_total_ff  <= total_ff;
         out_dev_ff    <= dev_ff;
         out_status_ff <= status_ff;
      end
   end

   assign out_valid        = out_valid_ff;
   assign out_executed     = out_exec_ff;
   assign out_total_value  = out_total_ff;
   assign out_deviation    = out_dev_ff;
   assign out_block_status = out_status_ff;

endmodule

`default_nettype wire

FILE: sv/pulse_totalizer_preset_alarm_unit.sv
// Each accepted item is checked against the period. If it does not elapse, the result is
// published; if it elapses once, one subtraction precedes the multiply, add and compare;
// when the ticks reach two periods or more, the 17-step restoring remainder loop precedes
// them. A held or first-sample execution skips the add and compare. One item at a time:
// the next is taken the cycle after the result is registered, later while a result waits.
// Reset is synchronous and active high; it restores the register defaults and clears state.
`default_nettype none

module pulse_totalizer_preset_alarm_unit
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   pta_req_if.sink                    req_channel,
   pta_rsp_if.source                  rsp_channel,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type            cmd;
   stat_type           stat;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_executed;
   logic [TOTAL_W-1:0] rsp_total;
   logic [DEV_W-1:0]   rsp_dev;
   logic [1:0]         rsp_status;

   // Sequencing of each item.
   pta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Registers, arithmetic and the output register.
   pta_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_elapsed_ticks (req_channel.elapsed_ticks),
      .in_pulse_count   (req_channel.pulse_count),
      .in_reset_request (req_channel.reset_request),
      .in_hold_switch   (req_channel.hold_switch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_channel.ready),
      .out_executed     (rsp_executed),
      .out_total_value  (rsp_total),
      .out_deviation    (rsp_dev),
      .out_block_status (rsp_status)
   );

   assign req_channel.ready        = req_ready;
   assign rsp_channel.valid        = rsp_valid;
   assign rsp_channel.executed     = rsp_executed;
   assign rsp_channel.total_value  = rsp_total;
   assign rsp_channel.deviation    = rsp_dev;
   assign rsp_channel.block_status = rsp_status;

   // The controller issues at most one command in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_in, cmd.acc_keep, cmd.acc_sub, cmd.mod_start, cmd.mod_step,
                cmd.mul, cmd.add, cmd.cmp, cmd.publish}))
      else $error("more than one datapath command in a cycle");

   // Once an item is taken, no further item is taken until its result is registered.
   assert property (@(posedge clock) disable iff (reset)
      req_channel.valid && req_ready |=> !req_ready)
      else $error("item accepted while the previous one is in progress");

   // A published result is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("published result not presented");

   // A result is only published when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || rsp_channel.ready))
      else $error("result overwrites one still waiting");

endmodule

`default_nettype wire

FILE: verif/pta_totalizer_watch.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the totalizer. Every accepted tick
// is run through a cycle-free model of the totalizer, and the result it predicts is
// queued. Every accepted result is compared with the oldest queued prediction.
module pta_totalizer_watch
   import pta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   pta_req_if                         req_mon,
   pta_rsp_if                         rsp_mon,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output int unsigned                failure_count,
   output int unsigned                outstanding
);

   localparam longint TOTAL_LIMIT = 64'sh0000_7FFF_FFFF_FFFF;

   typedef struct packed {
      logic                executed;
      logic [TOTAL_W-1:0]  total_value;
      logic [DEV_W-1:0]    deviation;
      block_status_type    block_status;
   } tick_result_type;

   // Register copies.
   logic [TICK_W-1:0]   period_cfg;
   logic [FACTOR_W-1:0] factor_cfg;
   longint              preset_cfg;
   longint              width_cfg;

   // Totalizer state.
   logic [ACC_W-1:0]    tick_acc;
   logic [COUNT_W-1:0]  latched_count;
   logic                count_latched;
   longint              total_acc;
   longint              deviation_acc;
   block_status_type    status_acc;

   tick_result_type     predicted_results[$];
   tick_result_type     due;
   int unsigned         issued;
   int unsigned         retired;

   assign outstanding = issued - retired;

   // Advances the totalizer by one tick and returns the result that it shows.
   function automatic tick_result_type advance_totalizer(input logic [TICK_W-1:0] ticks,
                                                         input logic [COUNT_W-1:0] count,
                                                         input logic rst,
                                                         input logic hold);
      logic [ACC_W-1:0]   period;
      logic [COUNT_W-1:0] pulse_diff;
      logic [PROD_W-1:0]  product;
      logic               had_sample;
      longint             threshold;
      tick_result_type    r;

      period = (period_cfg == '0) ? ACC_W'(1) : ACC_W'(period_cfg);
      tick_acc = tick_acc + ACC_W'(ticks);
      r.executed = 1'b0;
      if (tick_acc >= period) begin
         r.executed = 1'b1;
         had_sample = count_latched;
         pulse_diff = count - latched_count;
         tick_acc = tick_acc % period;
         latched_count = count;
         count_latched = 1'b1;
         // A reset request clears the total before this tick's pulses are added.
         if (rst) begin
            total_acc = 0;
         end
         if (hold) begin
            status_acc = STATUS_PAUSED;
         end else if (had_sample) begin
            product = {32'd0, factor_cfg} * {32'd0, pulse_diff};
            if (product > PROD_W'(TOTAL_LIMIT)) begin
               total_acc = TOTAL_LIMIT;
            end else begin
               total_acc = total_acc + longint'(product);
               if (total_acc > TOTAL_LIMIT) begin
                  total_acc = TOTAL_LIMIT;
               end
            end
            deviation_acc = preset_cfg - total_acc;
            threshold = preset_cfg - width_cfg;
            if (total_acc < threshold) begin
               status_acc = STATUS_NORMAL;
            end else if (total_acc >= preset_cfg) begin
               status_acc = STATUS_COUNTUP;
            end else begin
               status_acc = STATUS_PREALARM;
            end
         end
      end
      r.total_value = total_acc[TOTAL_W-1:0];
      r.deviation = deviation_acc[DEV_W-1:0];
      r.block_status = status_acc;
      return r;
   endfunction

   task automatic log_failure(input string detail);
      failure_count++;
      if (failure_count <= 10) begin
         $display("[%0t] result %0d: %s", $time, retired, detail);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         period_cfg <= PERIOD_RESET;
         factor_cfg <= FACTOR_RESET;
         preset_cfg = 0;
         width_cfg = 0;
         tick_acc = '0;
         latched_count = '0;
         count_latched = 1'b0;
         total_acc = 0;
         deviation_acc = 0;
         status_acc = STATUS_NORMAL;
         predicted_results.delete();
         failure_count = 0;
         issued <= 0;
         retired <= 0;
      end else begin
         // Register writes must only happen while the block is idle; the block does not enforce it.
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_CONTROL_PERIOD: period_cfg <= csr_write_data[TICK_W-1:0];
               CSR_PULSE_FACTOR:   factor_cfg <= csr_write_data[FACTOR_W-1:0];
               CSR_PRESET_VALUE:   preset_cfg = longint'($signed(csr_write_data[TOTAL_W-1:0]));
               CSR_PREALARM_WIDTH: width_cfg = longint'(csr_write_data[WIDTH_W-1:0]);
               default: ;
            endcase
         end

         // Results leave before a new tick is modelled, so the queue stays in order.
         if (rsp_mon.valid && rsp_mon.ready) begin
            retired <= retired + 1;
            if (predicted_results.size() == 0) begin
               log_failure($sformatf("unexpected result exec=%0b total=%h dev=%h status=%0d",
                                     rsp_mon.executed, rsp_mon.total_value,
                                     rsp_mon.deviation, rsp_mon.block_status));
            end else begin
               due = predicted_results.pop_front();
               if (rsp_mon.executed !== due.executed ||
                   rsp_mon.total_value !== due.total_value ||
                   rsp_mon.deviation !== due.deviation ||
                   rsp_mon.block_status !== due.block_status) begin
                  log_failure($sformatf({"mismatch: expected exec=%0b total=%h dev=%h ",
                                         "status=%0d, got exec=%0b total=%h dev=%h status=%0d"},
                                        due.executed, due.total_value, due.deviation,
                                        due.block_status, rsp_mon.executed,
                                        rsp_mon.total_value, rsp_mon.deviation,
                                        rsp_mon.block_status));
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            issued <= issued + 1;
            predicted_results.push_back(advance_totalizer(req_mon.elapsed_ticks,
                                                          req_mon.pulse_count,
                                                          req_mon.reset_request,
                                                          req_mon.hold_switch));
         end
      end
   end

endmodule

FILE: verif/pulse_totalizer_preset_alarm_unit_tb.sv
`timescale 1ns / 100ps

module pulse_totalizer_preset_alarm_unit_tb;
   import pta_pkg::*;

   localparam int          CLOCK_PERIOD = 12;
   localparam int          RESET_CYCLES = 7;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          LONG_STALL   = 300;
   localparam int          BLOCKS       = 8;
   localparam int          BLOCK_ITEMS  = 100;
   localparam int          DRAIN_CYCLES = 30;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int unsigned           failure_count;
   int unsigned           outstanding;
   int unsigned           cycle_count = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_idle_pct = 0;
   logic                  stall_requested = 1'b0;
   logic [TICK_W-1:0]     period_now = PERIOD_RESET;
   logic [COUNT_W-1:0]    count_now = '0;

   pta_req_if req_if();
   pta_rsp_if rsp_if();

   pulse_totalizer_preset_alarm_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pta_totalizer_watch u_watch (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failure_count    (failure_count),
      .outstanding      (outstanding)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result receiver: random back-pressure, plus one long hold-off when asked for.
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_requested && stall_cycles < LONG_STALL) begin
            stall_cycles++;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offers one tick item, with random idle cycles in front, and returns once it is taken.
   task automatic offer_tick(input logic [TICK_W-1:0] ticks, input logic [COUNT_W-1:0] count,
                             input logic rst, input logic hold);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.elapsed_ticks <= ticks;
      req_if.pulse_count <= count;
      req_if.reset_request <= rst;
      req_if.hold_switch <= hold;
      do @(posedge clock); while (!req_if.ready);
      count_now = count;
   endtask

   // Stops offering and waits until every predicted result has been received.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Writes all four registers on consecutive cycles.
   task automatic load_settings(input logic [TICK_W-1:0] period,
                                input logic [FACTOR_W-1:0] factor,
                                input logic [TOTAL_W-1:0] preset,
                                input logic [WIDTH_W-1:0] width);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CONTROL_PERIOD;
      csr_write_data <= CSR_DATA_W'(period);
      @(posedge clock);
      csr_index <= CSR_PULSE_FACTOR;
      csr_write_data <= CSR_DATA_W'(factor);
      @(posedge clock);
      csr_index <= CSR_PRESET_VALUE;
      csr_write_data <= CSR_DATA_W'(preset);
      @(posedge clock);
      csr_index <= CSR_PREALARM_WIDTH;
      csr_write_data <= CSR_DATA_W'(width);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      period_now = period;
   endtask

   initial begin
      logic [TICK_W-1:0]   ticks;
      logic [COUNT_W-1:0]  count;
      logic [TICK_W-1:0]   period;
      logic [FACTOR_W-1:0] factor;
      logic [TOTAL_W-1:0]  preset;
      logic [WIDTH_W-1:0]  width;
      int unsigned         limit;

      req_if.valid = 1'b0;
      req_if.elapsed_ticks = '0;
      req_if.pulse_count = '0;
      req_if.reset_request = 1'b0;
      req_if.hold_switch = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: no execution, first sample, reset without execution,
      // a plain add, hold across many periods, saturation, counter wrap with reset.
      offer_tick(16'd0, 32'd5, 1'b0, 1'b0);
      offer_tick(16'd1000, 32'd100, 1'b1, 1'b0);
      offer_tick(16'd10, 32'd150, 1'b1, 1'b0);
      offer_tick(16'd990, 32'd200, 1'b0, 1'b0);
      offer_tick(16'hFFFF, 32'd300, 1'b0, 1'b1);
      offer_tick(16'd1000, 32'hFFFF_FFFF, 1'b0, 1'b0);
      offer_tick(16'd1000, 32'h0000_0010, 1'b1, 1'b0);
      wait_drained();

      // A zero period acts as one; largest factor, preset and band.
      load_settings(16'd0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF);
      offer_tick(16'd0, 32'd0, 1'b0, 1'b0);
      offer_tick(16'd1, 32'd2, 1'b0, 1'b0);
      offer_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      offer_tick(16'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
      offer_tick(16'd2, 32'h8000_0000, 1'b0, 1'b0);
      wait_drained();

      // Longest period, zero factor, most negative preset.
      load_settings(16'hFFFF, 32'd0, 48'h8000_0000_0000, 47'd0);
      offer_tick(16'hFFFE, 32'd1, 1'b0, 1'b0);
      offer_tick(16'd1, 32'd7, 1'b0, 1'b0);
      offer_tick(16'hFFFF, 32'd9, 1'b1, 1'b0);
      wait_drained();

      // Walk through normal, prealarm at its threshold, count-up at the preset,
      // pause with dropped pulses, and a tick worth two periods.
      load_settings(16'd3, 32'd65536, 48'd1000 << 16, 47'd200 << 16);
      offer_tick(16'd3, 32'd9, 1'b1, 1'b0);
      offer_tick(16'd3, 32'd500, 1'b0, 1'b0);
      offer_tick(16'd3, 32'd809, 1'b0, 1'b0);
      offer_tick(16'd3, 32'd1009, 1'b0, 1'b0);
      offer_tick(16'd3, 32'd1100, 1'b0, 1'b1);
      offer_tick(16'd3, 32'd1200, 1'b0, 1'b0);
      offer_tick(16'd2, 32'd1300, 1'b0, 1'b0);
      offer_tick(16'd4, 32'd1300, 1'b0, 1'b0);
      wait_drained();

      // Random blocks, each with fresh settings. Counters mostly move forward by
      // modest steps so that the total can approach the preset.
      for (int blk = 0; blk < BLOCKS; blk++) begin
         if (blk < 3) begin
            send_idle_pct = 13;
            rsp_idle_pct <= 54;
         end else if (blk < 6) begin
            send_idle_pct = 54;
            rsp_idle_pct <= 13;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
         end

         case ($urandom_range(5))
            0:       period = 16'd0;
            1:       period = 16'd1;
            2:       period = 16'hFFFF;
            default: period = 16'($urandom_range(2, 40));
         endcase
         case ($urandom_range(4))
            0:       factor = 32'd0;
            1:       factor = 32'hFFFF_FFFF;
            2:       factor = $urandom;
            default: factor = $urandom_range(1, 1 << 18);
         endcase
         case ($urandom_range(4))
            0:       preset = 48'h8000_0000_0000;
            1:       preset = 48'h7FFF_FFFF_FFFF;
            2:       preset = 48'({$urandom, $urandom});
            default: preset = 48'($urandom) << $urandom_range(0, 8);
         endcase
         case ($urandom_range(3))
            0:       width = 47'd0;
            1:       width = 47'h7FFF_FFFF_FFFF;
            2:       width = 47'({$urandom, $urandom});
            default: width = 47'($urandom) << $urandom_range(0, 6);
         endcase
         load_settings(period, factor, preset, width);

         // The receiver holds off for a long stretch while ticks keep coming.
         if (blk == 1) begin
            stall_requested <= 1'b1;
         end

         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            limit = 2 * ((period_now == '0) ? 1 : int'(period_now));
            if (limit > 65535) begin
               limit = 65535;
            end
            if ($urandom_range(99) < 5) begin
               ticks = 16'($urandom);
            end else begin
               ticks = 16'($urandom_range(0, limit));
            end
            if ($urandom_range(99) < 4) begin
               count = $urandom;
            end else begin
               count = count_now + $urandom_range(0, 1000);
            end
            offer_tick(ticks, count, $urandom_range(99) < 6, $urandom_range(99) < 8);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
